FILE: rtl/core/bpad_pkg.sv
// ----------------------------------------------------------------------------
// bpad_pkg: shared types and constants for the buffered PWM audio DAC
// Request codes, register indexes, reset values and scale constants.
// ----------------------------------------------------------------------------
package bpad_pkg;

    // Request kinds carried in s_tuser
    typedef enum logic [1:0]
    {
        OP_TICK      = 2'd0,
        OP_WRITE     = 2'd1,
        OP_MARK_FULL = 2'd2,
        OP_EMPTY_ALL = 2'd3
    } bpad_op_t;

    // Configuration register indexes
    typedef enum logic
    {
        REG_ACTIVE_LEN = 1'b0,
        REG_PERIOD_LEN = 1'b1
    } bpad_reg_t;

    localparam int          CNT_W          = 10;
    localparam int          SAMPLE_W       = 8;
    localparam int          PROD_W         = CNT_W + SAMPLE_W;

    // 726-count period with a 107-count forced low gap
    localparam int          PERIOD_GAP     = 107;
    localparam int          PERIOD_RST     = 363 * 2;
    localparam int          ACTIVE_RST     = PERIOD_RST - PERIOD_GAP;
    localparam int          COMPARE_RST    = ACTIVE_RST - 1;

    localparam int          SAMPLE_FULL    = 255;
    localparam logic [7:0]  MIDSCALE       = 8'h80;

    localparam int          DEF_BUFFER_COUNT = 2;
    localparam int          DEF_BUFFER_SIZE  = 256;

    // Per-request flags that travel down the pipeline with the request
    typedef struct packed
    {
        logic             wrap;
        logic             underrun;
        logic             refill;
        logic             drained;
        logic [CNT_W-1:0] count;
    } bpad_flags_t;

endpackage

FILE: rtl/core/buffered_pwm_audio_dac.sv
// ----------------------------------------------------------------------------
// buffered_pwm_audio_dac: one-bit PWM audio output fed from sample buffers
// Period counter, compare update per period and a ring of sample buffers.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one request per cycle while s_tready is high: tick,
//   write sample, mark a buffer full, or empty all buffers (kind in s_tuser).
//   Every request gives exactly one result on m_*: the pin level after it,
//   plus refill, drained buffer and underrun flags on a tick that wraps the period.
//   cfg_* writes active_len (index 0) and period_len (index 1); write only
//   while no request is in flight.
//   A result passes the p1, p2, p3 and output registers before it shows
//   on m_tvalid. Throughput: one request per cycle while s_tready is high,
//   set by the single-port sample memory (one write or one read per request)
//   and the four-stage pipeline: fetch, multiply, divide by 255, pin compare.
//   Samples live in one synchronous memory of BUFFER_COUNT x BUFFER_SIZE
//   bytes; its contents are undefined after reset and are never cleared.
//   Reset: counter 0, compares 618, every buffer empty, ring at buffer 0.
//   Stall: while m_tready is low and a result waits, the whole pipeline
//   holds and s_tready drops; with the output register empty, requests keep
//   flowing into the pipeline.
// ----------------------------------------------------------------------------
module buffered_pwm_audio_dac
    import bpad_pkg::*;
#(
    parameter int BUFFER_COUNT = DEF_BUFFER_COUNT,
    parameter int BUFFER_SIZE  = DEF_BUFFER_SIZE
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [0] buffer_select, [8:1] sample_position,
                                    // [16:9] sample_value, rest zero
    input  logic [1:0]  s_tuser,    // [1:0] opcode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [0] pin_level, [1] refill_request,
                                    // [2] drained_buffer, [3] underrun, rest zero

    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_wdata
);

    localparam int BW        = $clog2(BUFFER_COUNT);
    localparam int AW        = $clog2(BUFFER_SIZE);
    localparam int PW        = $clog2(BUFFER_SIZE + 1);
    localparam int MEM_DEPTH = BUFFER_COUNT << AW;

    // Configuration registers
    logic [CNT_W-1:0] active_len_reg;
    logic [CNT_W-1:0] period_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_len_reg <= CNT_W'(ACTIVE_RST);
            period_len_reg <= CNT_W'(PERIOD_RST);
        end
        else if (cfg_wr_en)
        begin
            unique case (bpad_reg_t'(cfg_index))
                REG_ACTIVE_LEN: active_len_reg <= cfg_wdata;
                REG_PERIOD_LEN: period_len_reg <= cfg_wdata;
                default:        active_len_reg <= active_len_reg;
            endcase
        end
    end

    // Compare scale end
    logic [CNT_W-1:0] top;
    assign top = (active_len_reg == '0) ? '0 : active_len_reg - 1'b1;

    // Global advance: pipeline moves whenever the output register can load
    logic out_valid_reg;
    logic advance;
    logic s_fire;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign s_fire   = s_tvalid && advance;

    // Request fields
    bpad_op_t         op;
    logic             sel;
    logic [7:0]       pos;
    logic [7:0]       val;
    logic [BW-1:0]    sel_idx;
    logic             sel_ok;
    logic             pos_ok;

    assign op      = bpad_op_t'(s_tuser);
    assign sel     = s_tdata[0];
    assign pos     = s_tdata[8:1];
    assign val     = s_tdata[16:9];
    assign sel_idx = BW'(sel);
    assign sel_ok  = 32'(sel_idx) < BUFFER_COUNT;
    assign pos_ok  = 32'(pos) < BUFFER_SIZE;

    // Front stage state
    logic [CNT_W-1:0] period_count_reg;
    logic [BW-1:0]    read_buffer_reg;
    logic [PW-1:0]    read_pos_reg [BUFFER_COUNT];

    logic [CNT_W:0]   count_inc;
    logic             is_tick;
    logic             wrap0;
    logic [PW-1:0]    rp_cur;
    logic [PW-1:0]    rp_inc;
    logic             empty0;
    logic             refill0;
    logic [BW-1:0]    rb_adv;

    assign count_inc = {1'b0, period_count_reg} + 1'b1;
    assign is_tick   = (op == OP_TICK);
    assign wrap0     = is_tick && (count_inc >= {1'b0, period_len_reg});
    assign rp_cur    = read_pos_reg[read_buffer_reg];
    assign rp_inc    = rp_cur + 1'b1;
    assign empty0    = rp_cur >= PW'(BUFFER_SIZE);
    assign refill0   = !empty0 && (rp_inc >= PW'(BUFFER_SIZE));
    assign rb_adv    = (32'(read_buffer_reg) == BUFFER_COUNT - 1) ? '0
                                                                   : read_buffer_reg + 1'b1;

    // Counter, ring pointer and read positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_count_reg <= '0;
            read_buffer_reg  <= '0;
            for (int i = 0; i < BUFFER_COUNT; i++)
            begin
                read_pos_reg[i] <= PW'(BUFFER_SIZE);
            end
        end
        else if (s_fire)
        begin
            unique case (op)
                OP_TICK:
                begin
                    if (wrap0)
                    begin
                        period_count_reg <= '0;
                        if (!empty0)
                        begin
                            read_pos_reg[read_buffer_reg] <= rp_inc;
                            if (refill0)
                            begin
                                read_buffer_reg <= rb_adv;
                            end
                        end
                    end
                    else
                    begin
                        period_count_reg <= count_inc[CNT_W-1:0];
                    end
                end
                OP_WRITE:
                begin
                    period_count_reg <= period_count_reg;
                end
                OP_MARK_FULL:
                begin
                    if (sel_ok)
                    begin
                        read_pos_reg[sel_idx] <= '0;
                    end
                end
                OP_EMPTY_ALL:
                begin
                    for (int i = 0; i < BUFFER_COUNT; i++)
                    begin
                        read_pos_reg[i] <= PW'(BUFFER_SIZE);
                    end
                end
                default:
                begin
                    period_count_reg <= period_count_reg;
                end
            endcase
        end
    end

    // Sample memory: one write or one read per request
    logic [SAMPLE_W-1:0] sample_mem [MEM_DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;
    logic                mem_we;
    logic                mem_re;
    logic [BW+AW-1:0]    mem_waddr;
    logic [BW+AW-1:0]    mem_raddr;

    assign mem_we    = s_fire && (op == OP_WRITE) && sel_ok && pos_ok;
    assign mem_re    = s_fire && wrap0 && !empty0;
    assign mem_waddr = {sel_idx, AW'(pos)};
    assign mem_raddr = {read_buffer_reg, rp_cur[AW-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_mem[mem_waddr] <= val;
        end
        if (mem_re)
        begin
            rdata_reg <= sample_mem[mem_raddr];
        end
    end

    // Stage 1: flags beside the fetched sample
    logic        p1_valid_reg;
    bpad_flags_t p1_reg;
    bpad_flags_t p1_next;

    always_comb
    begin
        p1_next          = '0;
        p1_next.wrap     = wrap0;
        p1_next.underrun = wrap0 && empty0;
        p1_next.refill   = wrap0 && refill0;
        p1_next.drained  = wrap0 && refill0 && read_buffer_reg[0];
        if (wrap0)
        begin
            p1_next.count = '0;
        end
        else if (is_tick)
        begin
            p1_next.count = count_inc[CNT_W-1:0];
        end
        else
        begin
            p1_next.count = period_count_reg;
        end
    end

    // Stage 2: sample times scale end
    logic                p2_valid_reg;
    bpad_flags_t         p2_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SAMPLE_W-1:0] sample1;

    assign sample1 = p1_reg.underrun ? MIDSCALE : rdata_reg;

    // Stage 3: divide by 255 with one correction step
    logic              p3_valid_reg;
    bpad_flags_t       p3_reg;
    logic [CNT_W-1:0]  cmp_reg;
    logic [PROD_W:0]   div_sum;
    logic [PROD_W-8:0] q_est;
    logic [PROD_W:0]   q_times;
    logic [PROD_W:0]   rem;
    logic              rem_ge;
    logic [PROD_W:0]   rem_fix;
    logic [CNT_W-1:0]  quot;

    assign div_sum = {1'b0, prod_reg} + (PROD_W + 1)'(prod_reg >> 8)
                   + (PROD_W + 1)'(prod_reg >> 16);
    assign q_est   = div_sum[PROD_W:8];
    assign q_times = {q_est, 8'b0} - (PROD_W + 1)'(q_est);
    assign rem     = {1'b0, prod_reg} - q_times;
    assign rem_ge  = rem >= (PROD_W + 1)'(SAMPLE_FULL);
    assign rem_fix = rem_ge ? rem - (PROD_W + 1)'(SAMPLE_FULL) : rem;
    assign quot    = CNT_W'(q_est) + CNT_W'(rem_ge);

    // Output stage: compare state and pin level
    logic [CNT_W-1:0] current_cmp_reg;
    logic [CNT_W-1:0] next_cmp_reg;
    logic [CNT_W-1:0] cur_after;
    logic             pin;
    logic [7:0]       out_data_reg;

    assign cur_after = p3_reg.wrap ? next_cmp_reg : current_cmp_reg;
    assign pin       = (cur_after <= p3_reg.count) && (p3_reg.count < active_len_reg);

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg    <= 1'b0;
            p2_valid_reg    <= 1'b0;
            p3_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            current_cmp_reg <= CNT_W'(COMPARE_RST);
            next_cmp_reg    <= CNT_W'(COMPARE_RST);
        end
        else if (advance)
        begin
            p1_valid_reg  <= s_fire;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            out_valid_reg <= p3_valid_reg;
            if (p3_valid_reg && p3_reg.wrap)
            begin
                current_cmp_reg <= next_cmp_reg;
                next_cmp_reg    <= cmp_reg;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_reg       <= p1_next;
            p2_reg       <= p1_reg;
            prod_reg     <= PROD_W'(sample1) * PROD_W'(top);
            p3_reg       <= p2_reg;
            cmp_reg      <= top - quot;
            out_data_reg <= {4'b0, p3_reg.underrun, p3_reg.drained, p3_reg.refill, pin};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    // Ring pointer moves only on a wrap that drains a buffer
    a_ring_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(read_buffer_reg) |-> $past(s_fire && wrap0 && refill0))
        else $error("read buffer moved without a drain");

    // A refill request and an underrun never come from the same result
    a_refill_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[1] && m_tdata[3]))
        else $error("refill and underrun on one result");

    // Divider remainder lands below 255 after the correction step
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (p2_valid_reg && p2_reg.wrap) |-> (rem_fix < (PROD_W + 1)'(SAMPLE_FULL)))
        else $error("divide by 255 out of range");

    // A held result keeps the pipeline frozen
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> $stable(p3_valid_reg) && $stable(out_data_reg))
        else $error("pipeline moved under a stall");
`endif

endmodule
